### rtl/core/dpd_pkg.sv
`timescale 1ns / 1ps

package dpd_pkg;

    localparam int ERROR_WIDTH  = 16;

    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PWM_MAX     = 1'b0,
        REG_INTEG_LIMIT = 1'b1
    } cfg_reg_t;

    localparam logic [15:0] PWM_MAX_RESET     = 16'd3000;
    localparam logic [14:0] INTEG_LIMIT_RESET = 15'd12800;

    localparam int PID_SHIFT    = 14;
    localparam int P_PROD_W     = 32;
    localparam int D_PROD_W     = 33;
    localparam int I_PROD_W     = ERROR_WIDTH + 17;
    localparam int SUM_W        = ((I_PROD_W > D_PROD_W) ? I_PROD_W : D_PROD_W) + 2;
    localparam int PID_W        = SUM_W - PID_SHIFT;
    localparam int DRV_W        = ((PID_W > 17) ? PID_W : 17) + 1;
    localparam int ACC_W        = ((ERROR_WIDTH > 15) ? ERROR_WIDTH : 15) + 1;

    localparam logic [ACC_W-1:0] INTEG_MAX =
        ACC_W'((64'd1 << (ERROR_WIDTH - 1)) - 64'd1);

endpackage

### rtl/core/differential_pid_drive.sv
`timescale 1ns / 1ps

// Differential drive PID steering. One item per cycle is accepted unless
// out_stall back-pressure fills the pipeline. Each result passes the input,
// product and result registers in turn. The integral and previous-error
// state close their loop in the first stage, so every item sees the state
// left by the item just before it. pwm_max and integ_limit are written
// through the wr_en / wr_index / wr_data port; the user must write them only
// while the block is idle (not enforced by the block); reset 3000 and 12800.
module differential_pid_drive
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 wr_en,
    input  logic [dpd_pkg::CFG_IDX_W-1:0]        wr_index,
    input  logic [dpd_pkg::CFG_DATA_W-1:0]       wr_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [14:0]                   angle_error,
    input  logic [15:0]                          base_drive,
    input  logic [15:0]                          gain_p,
    input  logic [15:0]                          gain_i,
    input  logic [15:0]                          gain_d,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [15:0]                          left_drive,
    output logic [15:0]                          right_drive
);

    localparam int EW    = dpd_pkg::ERROR_WIDTH;
    localparam int SUM_W = dpd_pkg::SUM_W;
    localparam int DRV_W = dpd_pkg::DRV_W;
    localparam int ACC_W = dpd_pkg::ACC_W;

    logic [15:0]                    pwm_max_reg;
    logic [14:0]                    integ_limit_reg;

    logic signed [EW-1:0]           integ_reg;
    logic signed [EW-1:0]           integ_next;
    logic signed [14:0]             prev_error_reg;

    logic                           s1_valid_reg;
    logic signed [14:0]             s1_error_reg;
    logic [15:0]                    s1_base_reg;
    logic [15:0]                    s1_kp_reg;
    logic [15:0]                    s1_ki_reg;
    logic [15:0]                    s1_kd_reg;

    logic                           s2_valid_reg;
    logic [15:0]                    s2_base_reg;
    logic signed [dpd_pkg::P_PROD_W-1:0] s2_p_prod_reg;
    logic signed [dpd_pkg::I_PROD_W-1:0] s2_i_prod_reg;
    logic signed [dpd_pkg::D_PROD_W-1:0] s2_d_prod_reg;

    logic                           out_valid_reg;
    logic [15:0]                    left_reg;
    logic [15:0]                    right_reg;

    logic                           adv3;
    logic                           adv2;
    logic                           adv1;

    logic signed [15:0]             err_diff;
    logic signed [dpd_pkg::P_PROD_W-1:0] p_prod;
    logic signed [dpd_pkg::I_PROD_W-1:0] i_prod;
    logic signed [dpd_pkg::D_PROD_W-1:0] d_prod;

    logic [ACC_W-1:0]               lim_ext;
    logic signed [ACC_W-1:0]        lim;
    logic signed [ACC_W-1:0]        acc;
    logic signed [ACC_W-1:0]        acc_sat;

    logic signed [SUM_W-1:0]        sum;
    logic signed [dpd_pkg::PID_W-1:0] pid;
    logic signed [DRV_W-1:0]        base_ext;
    logic signed [DRV_W-1:0]        pid_ext;
    logic signed [DRV_W-1:0]        pwm_ext;
    logic signed [DRV_W-1:0]        left_raw;
    logic signed [DRV_W-1:0]        right_raw;
    logic [15:0]                    left_next;
    logic [15:0]                    right_next;

    function automatic logic [15:0] clamp_drive
    (
        input logic signed [DRV_W-1:0] v,
        input logic signed [DRV_W-1:0] vmax
    );
        logic [15:0] r;
        priority if (v <= $signed({DRV_W{1'b0}}))
        begin
            r = 16'd0;
        end
        else if (v >= vmax)
        begin
            r = vmax[15:0];
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    // pipeline flow
    assign adv3     = !out_valid_reg || !out_stall;
    assign adv2     = !s2_valid_reg || adv3;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_stall = !adv1;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_max_reg     <= dpd_pkg::PWM_MAX_RESET;
            integ_limit_reg <= dpd_pkg::INTEG_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (dpd_pkg::cfg_reg_t'(wr_index))
                dpd_pkg::REG_PWM_MAX:     pwm_max_reg     <= wr_data[15:0];
                dpd_pkg::REG_INTEG_LIMIT: integ_limit_reg <= wr_data[14:0];
            endcase
        end
    end

    // stage 1: products and state update
    assign err_diff = 16'(s1_error_reg) - 16'(prev_error_reg);
    assign p_prod   = $signed({1'b0, s1_kp_reg}) * s1_error_reg;
    assign i_prod   = $signed({1'b0, s1_ki_reg}) * integ_reg;
    assign d_prod   = $signed({1'b0, s1_kd_reg}) * err_diff;

    assign lim_ext  = ACC_W'(integ_limit_reg);

    always_comb
    begin
        lim = (lim_ext > dpd_pkg::INTEG_MAX) ? $signed(dpd_pkg::INTEG_MAX)
                                              : $signed(lim_ext);
        acc = ACC_W'(integ_reg) + ACC_W'(s1_error_reg);
        priority if (acc > lim)
        begin
            acc_sat = lim;
        end
        else if (acc < -lim)
        begin
            acc_sat = -lim;
        end
        else
        begin
            acc_sat = acc;
        end
        integ_next = $signed(acc_sat[EW-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            integ_reg      <= '0;
            prev_error_reg <= '0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                out_valid_reg <= s2_valid_reg;
            end
            if (s1_valid_reg && adv2)
            begin
                integ_reg      <= integ_next;
                prev_error_reg <= s1_error_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_error_reg <= angle_error;
            s1_base_reg  <= base_drive;
            s1_kp_reg    <= gain_p;
            s1_ki_reg    <= gain_i;
            s1_kd_reg    <= gain_d;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_base_reg   <= s1_base_reg;
            s2_p_prod_reg <= p_prod;
            s2_i_prod_reg <= i_prod;
            s2_d_prod_reg <= d_prod;
        end
        if (adv3 && s2_valid_reg)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    // stage 2: sum, shift and clamp
    assign sum       = SUM_W'(s2_p_prod_reg) + SUM_W'(s2_i_prod_reg) + SUM_W'(s2_d_prod_reg);
    assign pid       = $signed(sum[SUM_W-1:dpd_pkg::PID_SHIFT]);
    assign base_ext  = $signed({{(DRV_W-16){1'b0}}, s2_base_reg});
    assign pid_ext   = DRV_W'(pid);
    assign pwm_ext   = $signed({{(DRV_W-16){1'b0}}, pwm_max_reg});
    assign left_raw  = base_ext - pid_ext;
    assign right_raw = base_ext + pid_ext;
    assign left_next  = clamp_drive(left_raw, pwm_ext);
    assign right_next = clamp_drive(right_raw, pwm_ext);

    assign out_valid   = out_valid_reg;
    assign left_drive  = left_reg;
    assign right_drive = right_reg;

endmodule
